[src/u8hex_pkg.sv]
// Shared types and helpers for the UTF-8 to UCS-2 hex text converter.
package u8hex_pkg;

  // Kind of work handed from the decoder to the serializer.
  typedef enum logic {
    CMD_DIGITS = 1'b0,  // four hex digits of a complete code point
    CMD_MARKER = 1'b1   // empty end-of-string marker
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] code;  // code point, used by CMD_DIGITS
    logic        eos;   // final byte of the string produced this command
    logic        stop;  // halted status, used by CMD_MARKER
  } cmd_t;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [3:0] NibbleTen  = 4'd10;

  // Lowercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < NibbleTen) begin
      res = AsciiZero + {4'h0, nib};
    end else begin
      res = AsciiLowerA + {4'h0, nib - NibbleTen};
    end
    return res;
  endfunction

endpackage

[src/utf8_to_ucs2_hex_text.sv]
// Top level of the UTF-8 to UCS-2 hex text converter.
// A UTF-8 string enters one byte per transaction (tlast on its final byte) and
// leaves as lowercase ASCII hex digits, four per decoded 16-bit code point,
// most significant digit first, one digit per output transaction. Lead and
// continuation bytes that do not finish a code point give no output; a byte
// that finishes one gives four results, so the sustained rate is set by the
// serializer, which writes one digit per cycle while the output is ready:
// four digits per decoded code point whatever its byte count, and one result
// per end marker. A short command queue lets the decoder keep accepting bytes
// while the serializer drains earlier code points. An invalid lead byte stops
// conversion until the end of the string; a final byte that finishes no code
// point yields one empty result (tuser char_valid low) with tlast high and the
// stop status. Sequences cut short by the end of the string are dropped.
module utf8_to_ucs2_hex_text #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] hex_char
  output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] stopped_invalid
  output logic       m_axis_tlast    // last
);
  import u8hex_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;
  logic char_valid, stop;

  // Decode bytes; hold the input whenever the queue is full.
  u8hex_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .eos_i        (s_axis_tlast),
    .queue_full_i (q_full),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple decoder and serializer.
  u8hex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // Serialize each command into registered output transactions.
  u8hex_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_avail_i      (!q_empty),
    .cmd_i            (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_char_o       (m_axis_tdata),
    .out_char_valid_o (char_valid),
    .out_last_o       (m_axis_tlast),
    .out_stop_o       (stop)
  );

  assign m_axis_tuser = {stop, char_valid};

  // Input stalls only because the queue is full.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !q_full)
    else $error("input ready does not follow queue occupancy");

  // An empty marker always closes the string.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !char_valid) |-> m_axis_tlast)
    else $error("empty marker without last");

  // Digit results never carry the stop status.
  a_digit_nostop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && char_valid) |-> !stop)
    else $error("digit result flagged as stopped");

  // A push never meets a full queue, so none is lost.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into full queue");

endmodule

[src/u8hex_front.sv]
// UTF-8 decoder front end: accepts bytes and issues serializer commands.
module u8hex_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      byte_i,
  input  logic            eos_i,
  input  logic            queue_full_i,
  output logic            byte_ready_o,
  output logic            push_o,
  output u8hex_pkg::cmd_t cmd_o
);
  import u8hex_pkg::*;

  logic [15:0] acc_q, acc_d;
  logic [1:0]  left_q, left_d;
  logic        halted_q, halted_d;
  logic        fire;
  logic        complete;
  logic [15:0] acc_new;
  logic [1:0]  left_new;
  logic        halted_new;

  assign byte_ready_o = !queue_full_i;
  assign fire         = byte_valid_i && !queue_full_i;

  always_comb begin
    acc_new    = acc_q;
    left_new   = left_q;
    halted_new = halted_q;
    complete   = 1'b0;
    if (!halted_q) begin
      if (left_q != 2'd0) begin
        acc_new  = {acc_q[9:0], byte_i[5:0]};
        left_new = left_q - 2'd1;
        complete = (left_q == 2'd1);
      end else if (byte_i[7] == 1'b0) begin
        acc_new  = {8'h00, byte_i};
        complete = 1'b1;
      end else if (byte_i[7:5] == 3'b110) begin
        acc_new  = {11'h000, byte_i[4:0]};
        left_new = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        acc_new  = {12'h000, byte_i[3:0]};
        left_new = 2'd2;
      end else begin
        halted_new = 1'b1;
      end
    end
  end

  always_comb begin
    cmd_o.kind = complete ? CMD_DIGITS : CMD_MARKER;
    cmd_o.code = acc_new;
    cmd_o.eos  = eos_i;
    cmd_o.stop = halted_new;
    push_o     = fire && (complete || eos_i);
  end

  always_comb begin
    acc_d    = acc_q;
    left_d   = left_q;
    halted_d = halted_q;
    if (fire) begin
      acc_d    = complete ? 16'h0000 : acc_new;
      left_d   = left_new;
      halted_d = halted_new;
      if (eos_i) begin
        acc_d    = 16'h0000;
        left_d   = 2'd0;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 16'h0000;
      left_q   <= 2'd0;
      halted_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      left_q   <= left_d;
      halted_q <= halted_d;
    end
  end

endmodule

[src/u8hex_queue.sv]
// Small command queue between the decoder and the serializer.
module u8hex_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8hex_pkg::cmd_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output u8hex_pkg::cmd_t head_o
);
  import u8hex_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[src/u8hex_back.sv]
// Serializer back end: hex digit and marker results, one per cycle if ready.
module u8hex_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_avail_i,
  input  u8hex_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_char_valid_o,
  output logic            out_last_o,
  output logic            out_stop_o
);
  import u8hex_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       cv_q, cv_d, last_q, last_d, stop_q, stop_d;
  logic       load;
  logic [3:0] nib;

  assign load = cmd_avail_i && (!vld_q || out_ready_i);

  always_comb begin
    case (idx_q)
      2'd0:    nib = cmd_i.code[15:12];
      2'd1:    nib = cmd_i.code[11:8];
      2'd2:    nib = cmd_i.code[7:4];
      default: nib = cmd_i.code[3:0];
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    char_d = char_q;
    cv_d   = cv_q;
    last_d = last_q;
    stop_d = stop_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      unique case (cmd_i.kind)
        CMD_DIGITS: begin
          char_d = hex_ascii(nib);
          cv_d   = 1'b1;
          last_d = cmd_i.eos && (idx_q == 2'd3);
          stop_d = 1'b0;
          idx_d  = idx_q + 2'd1;
          pop_o  = (idx_q == 2'd3);
        end
        CMD_MARKER: begin
          char_d = 8'h00;
          cv_d   = 1'b0;
          last_d = 1'b1;
          stop_d = cmd_i.stop;
          idx_d  = 2'd0;
          pop_o  = 1'b1;
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    cv_q   <= cv_d;
    last_q <= last_d;
    stop_q <= stop_d;
  end

  assign out_valid_o      = vld_q;
  assign out_char_o       = char_q;
  assign out_char_valid_o = cv_q;
  assign out_last_o       = last_q;
  assign out_stop_o       = stop_q;

endmodule
